// File: sv/pso_pkg.sv
// ----------------------------------------------------------------------------
// pso_pkg
// Shared types, widths and constants of the phase accumulator sine oscillator.
// ----------------------------------------------------------------------------
`default_nettype none

package pso_pkg;

	localparam int PHASE_BITS  = 32;
	localparam int SAMPLE_BITS = 16;
	localparam int STEP_BITS   = 32;
	localparam int GAIN_BITS   = 16;
	localparam int IN_TDATA_W  = ((STEP_BITS + GAIN_BITS + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

	// phase alignment to Q0.32
	localparam int SH_UP = (PHASE_BITS >= 32) ? PHASE_BITS - 32 : 0;
	localparam int SH_DN = (PHASE_BITS < 32) ? 32 - PHASE_BITS : 0;

	// shared multiplier
	localparam int MUL_A_W = 33;
	localparam int MUL_B_W = 32;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int ACC_W   = 35;
	localparam int OSH     = 48 - SAMPLE_BITS;

	localparam logic [MUL_B_W-1:0] PI_Q30 = 32'd3373259426;
	localparam logic [PROD_W-1:0]  RND30  = PROD_W'(1) << 29;
	localparam logic [PROD_W-1:0]  RNDO   = PROD_W'(1) << (OSH - 1);
	localparam logic [30:0]        QUARTER = 31'h4000_0000;
	localparam logic [31:0]        HALF    = 32'h8000_0000;
	localparam logic signed [ACC_W-1:0] HC6 = 35'sd1;

	typedef struct packed {
		logic                 neg;
		logic [30:0]          h;
		logic [GAIN_BITS-1:0] gain;
	} pso_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_ADJ
	} pso_state_t;

	typedef enum logic [3:0] {
		OP_X,
		OP_X2,
		OP_H5,
		OP_H4,
		OP_H3,
		OP_H2,
		OP_H1,
		OP_H0,
		OP_S,
		OP_M
	} pso_op_t;

	// odd Taylor terms in Q32
	function automatic logic signed [ACC_W-1:0] horner_coef(input pso_op_t op);
		logic signed [ACC_W-1:0] c;
		case (op)
			OP_H5:   c = -35'sd108;
			OP_H4:   c = 35'sd11836;
			OP_H3:   c = -35'sd852176;
			OP_H2:   c = 35'sd35791394;
			OP_H1:   c = -35'sd715827883;
			OP_H0:   c = 35'sd4294967296;
			default: c = '0;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

// File: sv/pso_front.sv
// ----------------------------------------------------------------------------
// pso_front
// Accepts sample ticks, advances the phase accumulator, folds the phase to
// the first quadrant and hands a work item to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module pso_front
	import pso_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_valid,
	output logic                      s_ready,
	input  wire logic [STEP_BITS-1:0] step,
	input  wire logic [GAIN_BITS-1:0] gain,
	input  wire logic                 q_ready,
	output logic                      q_push,
	output pso_item_t                 q_item
);

	logic [PHASE_BITS-1:0] acc_q;
	logic [GAIN_BITS-1:0]  gain_q;
	logic                  valid_q;
	logic [PHASE_BITS-1:0] step_al;
	logic [31:0]           p;
	logic [30:0]           h;
	logic                  accept;

	always_comb begin
		if (PHASE_BITS >= 32) begin
			step_al = PHASE_BITS'(step) << SH_UP;
			p       = 32'(acc_q >> SH_UP);
		end else begin
			step_al = PHASE_BITS'(step >> SH_DN);
			p       = 32'(acc_q) << SH_DN;
		end
		h = p[30:0];
		if (h > QUARTER) begin
			h = 31'(HALF - {1'b0, h});
		end
	end

	assign q_push      = valid_q && q_ready;
	assign s_ready     = !valid_q || q_ready;
	assign accept      = s_valid && s_ready;
	assign q_item.neg  = p[31];
	assign q_item.h    = h;
	assign q_item.gain = gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (accept) begin
				acc_q   <= acc_q + step_al;
				valid_q <= 1'b1;
			end else if (q_push) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			gain_q <= gain;
		end
	end

endmodule

`default_nettype wire

// File: sv/pso_fifo.sv
// ----------------------------------------------------------------------------
// pso_fifo
// Two-entry queue of work items between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module pso_fifo
	import pso_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire pso_item_t wr_item,
	output logic           ready,
	input  wire logic      pop,
	output logic           valid,
	output pso_item_t      rd_item
);

	pso_item_t  mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign ready   = (cnt_q != 2'd2);
	assign valid   = (cnt_q != 2'd0);
	assign rd_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule

`default_nettype wire

// File: sv/pso_back.sv
// ----------------------------------------------------------------------------
// pso_back
// Sequencer around one shared multiplier: phase to radians, x squared,
// Horner terms, sine, gain, then round, saturate and sign into the output
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module pso_back
	import pso_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   q_valid,
	input  wire pso_item_t              q_item,
	output logic                        q_pop,
	output logic                        m_valid,
	input  wire logic                   m_ready,
	output logic [SAMPLE_BITS-1:0]      m_sample
);

	pso_state_t state_q, state_d;
	pso_op_t    op_q;
	logic       load_out;
	logic       out_valid_q;

	logic                    neg_q;
	logic [30:0]             h_q;
	logic [GAIN_BITS-1:0]    gain_q;
	logic [30:0]             x_q;
	logic [31:0]             x2_q;
	logic signed [ACC_W-1:0] acc_q;
	logic [MUL_A_W-1:0]      s_q;
	logic [PROD_W-1:0]       prod_q;
	logic [SAMPLE_BITS-1:0]  sample_q;

	logic [MUL_A_W-1:0]      mul_a;
	logic [MUL_B_W-1:0]      mul_b;
	logic signed [ACC_W-1:0] acc_abs;
	logic [PROD_W-1:0]       rnd30;
	logic signed [ACC_W-1:0] term;
	logic [PROD_W-1:0]       m_full;
	logic [PROD_W-1:0]       lim;
	logic [SAMPLE_BITS-1:0]  mag;

	always_comb begin
		acc_abs = acc_q[ACC_W-1] ? -acc_q : acc_q;
		unique case (op_q)
			OP_X: begin
				mul_a = MUL_A_W'(h_q);
				mul_b = PI_Q30;
			end
			OP_X2: begin
				mul_a = MUL_A_W'(x_q);
				mul_b = MUL_B_W'(x_q);
			end
			OP_S: begin
				mul_a = acc_q[ACC_W-1] ? '0 : MUL_A_W'(acc_q);
				mul_b = MUL_B_W'(x_q);
			end
			OP_M: begin
				mul_a = s_q;
				mul_b = MUL_B_W'(gain_q);
			end
			default: begin
				mul_a = MUL_A_W'(acc_abs);
				mul_b = x2_q;
			end
		endcase

		rnd30 = (prod_q + RND30) >> 30;
		term  = acc_q[ACC_W-1] ? -ACC_W'(rnd30) : ACC_W'(rnd30);

		m_full = (prod_q + RNDO) >> OSH;
		lim    = neg_q ? (PROD_W'(1) << (SAMPLE_BITS - 1))
		               : ((PROD_W'(1) << (SAMPLE_BITS - 1)) - PROD_W'(1));
		mag    = (m_full > lim) ? SAMPLE_BITS'(lim) : SAMPLE_BITS'(m_full);
	end

	always_comb begin
		state_d  = state_q;
		q_pop    = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					q_pop   = 1'b1;
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				state_d = ST_ADJ;
			end
			ST_ADJ: begin
				if (op_q == OP_M) begin
					if (!out_valid_q || m_ready) begin
						load_out = 1'b1;
						state_d  = ST_IDLE;
					end
				end else begin
					state_d = ST_MUL;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_X;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (q_pop) begin
				op_q <= OP_X;
			end else if (state_q == ST_ADJ && op_q != OP_M) begin
				op_q <= pso_op_t'(op_q + 4'd1);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			neg_q  <= q_item.neg;
			h_q    <= q_item.h;
			gain_q <= q_item.gain;
			acc_q  <= HC6;
		end
		if (state_q == ST_MUL) begin
			prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
		end
		if (state_q == ST_ADJ) begin
			unique case (op_q)
				OP_X:    x_q  <= 31'(prod_q >> 31);
				OP_X2:   x2_q <= 32'(rnd30);
				OP_S:    s_q  <= MUL_A_W'(rnd30);
				OP_M:    ;
				default: acc_q <= horner_coef(op_q) + term;
			endcase
		end
		if (load_out) begin
			sample_q <= neg_q ? -mag : mag;
		end
	end

	assign m_valid  = out_valid_q;
	assign m_sample = sample_q;

endmodule

`default_nettype wire

// File: sv/phase_accumulator_sine_oscillator_top.sv
// ----------------------------------------------------------------------------
// phase_accumulator_sine_oscillator_top
// Each request takes ten passes through the shared 33x32 multiplier, each a
// multiply state and an adjust state, after one dispatch state. The back end
// takes no new item from the queue until the last sample is in its output register.
// Reset: asynchronous, active low; clears the phase accumulator and the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module phase_accumulator_sine_oscillator_top
	import pso_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,  // phase_step[31:0], gain[47:32]
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0]      m_axis_tdata   // sample[15:0]
);

	logic                   q_push;
	logic                   q_ready;
	pso_item_t              f_item;
	logic                   q_valid;
	logic                   q_pop;
	pso_item_t              b_item;
	logic [SAMPLE_BITS-1:0] sample;

	pso_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_axis_tvalid),
		.s_ready (s_axis_tready),
		.step    (s_axis_tdata[STEP_BITS-1:0]),
		.gain    (s_axis_tdata[STEP_BITS+GAIN_BITS-1:STEP_BITS]),
		.q_ready (q_ready),
		.q_push  (q_push),
		.q_item  (f_item)
	);

	pso_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_item (f_item),
		.ready   (q_ready),
		.pop     (q_pop),
		.valid   (q_valid),
		.rd_item (b_item)
	);

	pso_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_item   (b_item),
		.q_pop    (q_pop),
		.m_valid  (m_axis_tvalid),
		.m_ready  (m_axis_tready),
		.m_sample (sample)
	);

	assign m_axis_tdata = OUT_TDATA_W'(sample);

endmodule

`default_nettype wire

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Streaming testbench for the phase accumulator sine oscillator. Sample ticks
// carrying a phase step and a gain are pushed through the slave port with a
// random sender idle pattern. Every accepted request advances a local phase
// accumulator, and the expected Q1.15 sample is computed bit exact in fixed
// point. Samples leaving the master port under random backpressure are
// compared in order against those predictions.
// ----------------------------------------------------------------------------

module tb_top
	import pso_pkg::*;
;

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [STEP_BITS-1:0] step;
		logic [GAIN_BITS-1:0] gain;
	} tick_t;

	localparam int NUM_PHASES   = 4;
	localparam int TICKS_PER_PH = 300;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 48;
	localparam int MAX_REPORTS  = 10;
	localparam logic [GAIN_BITS-1:0] UNITY = 16'd32768;

	localparam longint TAYLOR [0:6] = '{
		64'sd4294967296, -64'sd715827883, 64'sd35791394, -64'sd852176,
		64'sd11836, -64'sd108, 64'sd1
	};

	localparam int SRC_IDLE_PCT [0:NUM_PHASES-1] = '{0, 49, 0, 34};
	localparam int SNK_STALL_PCT [0:NUM_PHASES-1] = '{0, 0, 49, 34};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	tick_t tick_q[$];
	logic [SAMPLE_BITS-1:0] sample_q[$];
	logic [PHASE_BITS-1:0] phase_acc = '0;
	tick_t drive_tick;
	logic src_fire = 1'b0;
	logic sink_hold = 1'b0;
	logic hold_arm = 1'b0;
	int src_idle_pct = 0;
	int snk_stall_pct = 0;
	int mismatch_cnt = 0;

	phase_accumulator_sine_oscillator_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [63:0] rnd_mul(input logic [63:0] a, input logic [63:0] b,
			input int sh);
		return (a * b + (64'd1 << (sh - 1))) >> sh;
	endfunction

	// sine of a Q0.32 phase, scaled by gain, as a signed Q1.15 code
	function automatic logic [SAMPLE_BITS-1:0] sine_sample(input logic [31:0] p,
			input logic [GAIN_BITS-1:0] gain);
		logic [63:0] h, x, x2, mag, s, m, lim;
		longint a;
		logic neg;
		int k;
		neg = p[31];
		h = {33'd0, p[30:0]};
		if (h > 64'h4000_0000) begin
			h = 64'h8000_0000 - h;
		end
		x = (h * 64'(PI_Q30)) >> 31;
		x2 = rnd_mul(x, x, 30);
		a = TAYLOR[6];
		for (k = 5; k >= 0; k--) begin
			mag = rnd_mul((a < 0) ? 64'(-a) : 64'(a), x2, 30);
			a = TAYLOR[k] + ((a < 0) ? -$signed(mag) : $signed(mag));
		end
		if (a < 0) begin
			a = 0;
		end
		s = rnd_mul(64'(a), x, 30);
		m = rnd_mul(s, 64'(gain), OSH);
		lim = neg ? (64'd1 << (SAMPLE_BITS - 1)) : (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
		if (m > lim) begin
			m = lim;
		end
		return SAMPLE_BITS'(neg ? 64'd0 - m : m);
	endfunction

	function automatic tick_t random_tick();
		tick_t t;
		case ($urandom_range(9))
			0, 1, 2, 3, 4: t.step = $urandom();
			5, 6:          t.step = $urandom_range(32'h0100_0000);
			7:             t.step = {2'($urandom_range(3)), 30'd0} + $urandom_range(8) - 4;
			default:       t.step = $urandom_range(1) ? 32'hFFFF_FFFF - $urandom_range(16)
					: $urandom_range(16);
		endcase
		case ($urandom_range(9))
			0, 1, 2, 3, 4, 5: t.gain = GAIN_BITS'($urandom_range(32768));
			6:                t.gain = UNITY;
			7:                t.gain = GAIN_BITS'($urandom_range(65535));
			8:                t.gain = GAIN_BITS'($urandom_range(3));
			default:          t.gain = GAIN_BITS'($urandom_range(65535, 32769));
		endcase
		return t;
	endfunction

	task automatic push_tick(input logic [31:0] step, input logic [GAIN_BITS-1:0] gain);
		tick_t t;
		t.step = step;
		t.gain = gain;
		tick_q.push_back(t);
	endtask

	task automatic flag_error(input string msg);
		if (mismatch_cnt < MAX_REPORTS) begin
			$display("%0t ns: %s", $realtime, msg);
		end
		mismatch_cnt++;
	endtask

	task automatic drain();
		while (tick_q.size() != 0 || s_axis_tvalid) begin
			@(posedge clk);
		end
		while (sample_q.size() != 0) begin
			@(negedge clk);
		end
		@(posedge clk);
	endtask

	// request driver
	always @(negedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || src_fire) begin
			if (tick_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
				drive_tick = tick_q.pop_front();
				s_axis_tdata <= IN_TDATA_W'({drive_tick.gain, drive_tick.step});
				s_axis_tvalid <= 1'b1;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= !sink_hold && ($urandom_range(99) >= snk_stall_pct);
		end
	end

	// long sink hold-off so the block backs up into its input
	initial begin
		wait (hold_arm);
		@(negedge clk);
		sink_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(negedge clk);
		sink_hold <= 1'b0;
	end

	// monitor and checker
	always @(posedge clk) begin
		logic [PHASE_BITS-1:0] step_al;
		logic [SAMPLE_BITS-1:0] want, got;
		src_fire <= arst_n && s_axis_tvalid && s_axis_tready;
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			step_al = PHASE_BITS'((64'(s_axis_tdata[STEP_BITS-1:0]) << SH_UP) >> SH_DN);
			phase_acc = phase_acc + step_al;
			sample_q.push_back(sine_sample(32'((64'(phase_acc) >> SH_UP) << SH_DN),
					s_axis_tdata[STEP_BITS +: GAIN_BITS]));
		end
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[SAMPLE_BITS-1:0];
			if (sample_q.size() == 0) begin
				flag_error($sformatf("unexpected sample %0d, none pending", $signed(got)));
			end else begin
				want = sample_q.pop_front();
				if (got !== want) begin
					flag_error($sformatf("sample mismatch: expected %0d, got %0d",
							$signed(want), $signed(got)));
				end
			end
		end
	end

	initial begin
		#10ms;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		int ph;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// quarter steps from zero phase: zero, +peak, zero, -peak, zero
		push_tick(32'h0000_0000, UNITY);
		push_tick(32'h4000_0000, UNITY);
		push_tick(32'h4000_0000, UNITY);
		push_tick(32'h4000_0000, UNITY);
		push_tick(32'h4000_0000, UNITY);
		// above unity at both peaks
		push_tick(32'h4000_0000, 16'hFFFF);
		push_tick(32'h8000_0000, 16'hFFFF);
		push_tick(32'h4000_0000, 16'd0);
		push_tick(32'h2000_0000, 16'd0);
		push_tick(32'h0000_0001, 16'd1);
		push_tick(32'hFFFF_FFFF, UNITY);
		push_tick(32'h7FFF_FFFF, 16'd16384);
		push_tick(32'h8000_0000, UNITY);
		push_tick(32'h0000_0001, 16'h8001);
		push_tick(32'h4000_0001, 16'h7FFF);
		push_tick(32'hFFFF_FFFE, 16'hAAAA);
		push_tick(32'h5555_5555, 16'h5555);
		push_tick(32'hAAAA_AAAA, UNITY);
		push_tick(32'h0000_0000, UNITY);

		for (ph = 0; ph < NUM_PHASES; ph++) begin
			src_idle_pct = SRC_IDLE_PCT[ph];
			snk_stall_pct = SNK_STALL_PCT[ph];
			if (ph == 0) begin
				hold_arm = 1'b1;
			end
			if (ph == 2) begin
				repeat (TICKS_PER_PH / 2) tick_q.push_back(random_tick());
				drain();
				repeat (TICKS_PER_PH / 2) tick_q.push_back(random_tick());
			end else begin
				repeat (TICKS_PER_PH) tick_q.push_back(random_tick());
			end
			drain();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_cnt == 0 && sample_q.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
